[rtl/tscr_pkg.sv]
// ----------------------------------------------------------------------------
// tscr_pkg
// Shared types, constants and helpers of the tempo step clock with ratio sync.
// ----------------------------------------------------------------------------
package tscr_pkg;

   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned STEP_W      = 8;
   localparam int unsigned RATIO_W     = 8;
   localparam int unsigned BPM_W       = 10;
   localparam int unsigned CSR_DATA_W  = 10;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned DIVIDEND_W  = 24;
   localparam int unsigned DIV_COUNT_W = $clog2(DIVIDEND_W);

   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
   localparam logic [PERIOD_W-1:0] MS_PER_MIN   = 16'd60000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd666;
   localparam logic [PERIOD_W-1:0] BPM_RESET    = 16'd90;
   localparam logic [RATIO_W-1:0]  RATIO_RESET  = 8'd1;
   localparam logic [RATIO_W-1:0]  WRAP_RESET   = 8'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEMPO = 2'd0,
      CSR_NUM   = 2'd1,
      CSR_DEN   = 2'd2,
      CSR_WRAP  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DSEL_TEMPO = 2'd0,
      DSEL_SCALE = 2'd1,
      DSEL_BPM   = 2'd2,
      DSEL_WRAP  = 2'd3
   } div_sel_type;

   typedef struct packed {
      logic        cfg_write;
      logic        tick;
      logic        mul;
      logic        div_start;
      logic        div_store;
      div_sel_type div_sel;
      logic        finish_resync;
      logic        finish_ratio;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic cfg_tempo_div;
      logic cfg_ratio_change;
      logic mp_nonzero;
      logic resync_due;
      logic step_due;
      logic wrap_zero;
      logic div_done;
      logic rsp_free;
   } status_type;

   // saturate at the top, floor at one
   function automatic logic [PERIOD_W-1:0] bound_period(input logic [DIVIDEND_W-1:0] q);
      logic [PERIOD_W-1:0] r;
      if (q > DIVIDEND_W'(PERIOD_MAX)) begin
         r = PERIOD_MAX;
      end else if (q == '0) begin
         r = PERIOD_W'(1);
      end else begin
         r = q[PERIOD_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/tscr_div.sv]
// ----------------------------------------------------------------------------
// tscr_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tscr_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tscr_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [tscr_pkg::PERIOD_W-1:0]       divisor,
   output logic                                done,
   output logic [tscr_pkg::DIVIDEND_W-1:0]     quotient,
   output logic [tscr_pkg::PERIOD_W-1:0]       remainder
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [tscr_pkg::DIV_COUNT_W-1:0]     count_ff, count_in;
   logic [tscr_pkg::DIVIDEND_W-1:0]      quo_ff, quo_in;
   logic [tscr_pkg::PERIOD_W-1:0]        rem_ff, rem_in;
   logic [tscr_pkg::PERIOD_W-1:0]        dsr_ff, dsr_in;
   logic [tscr_pkg::PERIOD_W:0]          shifted;
   logic [tscr_pkg::PERIOD_W:0]          trial;
   logic                                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[tscr_pkg::DIVIDEND_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      trial   = shifted - {1'b0, dsr_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = tscr_pkg::DIV_COUNT_W'(tscr_pkg::DIVIDEND_W - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[tscr_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[tscr_pkg::PERIOD_W-1:0] : shifted[tscr_pkg::PERIOD_W-1:0];
         count_in = count_ff - tscr_pkg::DIV_COUNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/tscr_dp.sv]
// ----------------------------------------------------------------------------
// tscr_dp
// Datapath: clock state, ratio registers, shared divider and result register.
// ----------------------------------------------------------------------------
module tscr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tscr_pkg::cmd_type                   cmd,
   output tscr_pkg::status_type                status,
   input  logic [tscr_pkg::PERIOD_W-1:0]       req_master_period,
   input  logic [tscr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tscr_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tscr_pkg::PERIOD_W-1:0]       rsp_event_period,
   output logic [tscr_pkg::STEP_W-1:0]         rsp_step_index,
   output logic [tscr_pkg::PERIOD_W-1:0]       rsp_current_bpm
);

   logic [tscr_pkg::RATIO_W-1:0]     num_ff, num_in;
   logic [tscr_pkg::RATIO_W-1:0]     den_ff, den_in;
   logic [tscr_pkg::RATIO_W-1:0]     wrap_ff, wrap_in;
   logic [tscr_pkg::BPM_W-1:0]       tempo_ff, tempo_in;
   logic [tscr_pkg::PERIOD_W-1:0]    elapsed_ff, elapsed_in;
   logic [tscr_pkg::STEP_W-1:0]      count_ff, count_in;
   logic [tscr_pkg::PERIOD_W-1:0]    period_ff, period_in;
   logic [tscr_pkg::PERIOD_W-1:0]    ref_ff, ref_in;
   logic [tscr_pkg::PERIOD_W-1:0]    bpm_ff, bpm_in;
   logic [tscr_pkg::RATIO_W-1:0]     mcount_ff, mcount_in;
   logic [tscr_pkg::PERIOD_W-1:0]    event_ff, event_in;
   logic [tscr_pkg::DIVIDEND_W-1:0]  product_ff, product_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tscr_pkg::PERIOD_W-1:0]    rsp_event_ff, rsp_event_in;
   logic [tscr_pkg::STEP_W-1:0]      rsp_step_ff, rsp_step_in;
   logic [tscr_pkg::PERIOD_W-1:0]    rsp_bpm_ff, rsp_bpm_in;

   tscr_pkg::csr_index_type          csr_sel;
   logic [tscr_pkg::RATIO_W-1:0]     cfg_v8;
   logic [tscr_pkg::PERIOD_W-1:0]    elapsed_inc;
   logic [tscr_pkg::STEP_W:0]        count_inc;
   logic [tscr_pkg::DIVIDEND_W-1:0]  div_dividend;
   logic [tscr_pkg::PERIOD_W-1:0]    div_divisor;
   logic                             div_done;
   logic [tscr_pkg::DIVIDEND_W-1:0]  div_quo;
   logic [tscr_pkg::PERIOD_W-1:0]    div_rem;

   tscr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign csr_sel     = tscr_pkg::csr_index_type'(csr_index);
   assign cfg_v8      = csr_data[tscr_pkg::RATIO_W-1:0];
   assign elapsed_inc = (elapsed_ff == tscr_pkg::PERIOD_MAX) ?
                        elapsed_ff : elapsed_ff + tscr_pkg::PERIOD_W'(1);
   assign count_inc   = {1'b0, count_ff} + (tscr_pkg::STEP_W+1)'(1);

   always_comb begin
      status.cfg_tempo_div    = (csr_sel == tscr_pkg::CSR_TEMPO) && (csr_data != '0);
      status.cfg_ratio_change = ((csr_sel == tscr_pkg::CSR_NUM) && (cfg_v8 != num_ff)) ||
                                ((csr_sel == tscr_pkg::CSR_DEN) && (cfg_v8 != den_ff));
      status.mp_nonzero       = req_master_period != '0;
      status.resync_due       = mcount_ff >= num_ff;
      status.step_due         = (den_ff != '0) && (count_inc < {1'b0, den_ff}) &&
                                (elapsed_inc >= period_ff);
      status.wrap_zero        = wrap_ff == '0;
      status.div_done         = div_done;
      status.rsp_free         = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.div_sel)
         tscr_pkg::DSEL_TEMPO: begin
            div_dividend = tscr_pkg::DIVIDEND_W'(tscr_pkg::MS_PER_MIN);
            div_divisor  = tscr_pkg::PERIOD_W'(csr_data);
         end
         tscr_pkg::DSEL_SCALE: begin
            div_dividend = product_ff;
            div_divisor  = tscr_pkg::PERIOD_W'(den_ff);
         end
         tscr_pkg::DSEL_BPM: begin
            div_dividend = tscr_pkg::DIVIDEND_W'(tscr_pkg::MS_PER_MIN);
            div_divisor  = period_ff;
         end
         tscr_pkg::DSEL_WRAP: begin
            div_dividend = tscr_pkg::DIVIDEND_W'(count_inc);
            div_divisor  = tscr_pkg::PERIOD_W'(wrap_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      wrap_in    = wrap_ff;
      tempo_in   = tempo_ff;
      elapsed_in = elapsed_ff;
      count_in   = count_ff;
      period_in  = period_ff;
      ref_in     = ref_ff;
      bpm_in     = bpm_ff;
      mcount_in  = mcount_ff;
      event_in   = event_ff;
      product_in = product_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_bpm_in   = rsp_bpm_ff;

      if (cmd.cfg_write) begin
         case (csr_sel)
            tscr_pkg::CSR_TEMPO: begin
               tempo_in = csr_data;
               if (csr_data == '0) begin
                  period_in = tscr_pkg::PERIOD_MAX;
                  ref_in    = tscr_pkg::PERIOD_MAX;
                  bpm_in    = '0;
               end
            end
            tscr_pkg::CSR_NUM:  num_in  = cfg_v8;
            tscr_pkg::CSR_DEN:  den_in  = cfg_v8;
            tscr_pkg::CSR_WRAP: wrap_in = cfg_v8;
            default: ;
         endcase
      end

      if (cmd.tick) begin
         if (status.mp_nonzero) begin
            if (status.resync_due) begin
               ref_in = req_master_period;
            end else begin
               mcount_in = mcount_ff + tscr_pkg::RATIO_W'(1);
               event_in  = '0;
            end
         end else if (status.step_due) begin
            elapsed_in = '0;
            event_in   = period_ff;
            if (status.wrap_zero) begin
               count_in = count_inc[tscr_pkg::STEP_W-1:0];
            end
         end else begin
            elapsed_in = elapsed_inc;
            event_in   = '0;
         end
      end

      if (cmd.mul) begin
         product_in = tscr_pkg::DIVIDEND_W'(ref_ff) * tscr_pkg::DIVIDEND_W'(num_ff);
      end

      if (cmd.div_store) begin
         case (cmd.div_sel)
            tscr_pkg::DSEL_TEMPO: begin
               period_in = tscr_pkg::bound_period(div_quo);
               ref_in    = tscr_pkg::bound_period(div_quo);
               bpm_in    = tscr_pkg::PERIOD_W'(tempo_ff);
            end
            tscr_pkg::DSEL_SCALE: period_in = tscr_pkg::bound_period(div_quo);
            tscr_pkg::DSEL_BPM:   bpm_in    = div_quo[tscr_pkg::PERIOD_W-1:0];
            tscr_pkg::DSEL_WRAP:  count_in  = div_rem[tscr_pkg::STEP_W-1:0];
            default: ;
         endcase
      end

      if (cmd.finish_resync) begin
         elapsed_in = '0;
         count_in   = '0;
         mcount_in  = tscr_pkg::RATIO_W'(1);
         event_in   = period_ff;
      end

      if (cmd.finish_ratio) begin
         count_in = '0;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = event_ff;
         rsp_step_in  = count_ff;
         rsp_bpm_in   = bpm_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= tscr_pkg::RATIO_RESET;
         den_ff       <= tscr_pkg::RATIO_RESET;
         wrap_ff      <= tscr_pkg::WRAP_RESET;
         elapsed_ff   <= '0;
         count_ff     <= '0;
         period_ff    <= tscr_pkg::PERIOD_RESET;
         ref_ff       <= tscr_pkg::PERIOD_RESET;
         bpm_ff       <= tscr_pkg::BPM_RESET;
         mcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         den_ff       <= den_in;
         wrap_ff      <= wrap_in;
         elapsed_ff   <= elapsed_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         ref_ff       <= ref_in;
         bpm_ff       <= bpm_in;
         mcount_ff    <= mcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tempo_ff     <= tempo_in;
      event_ff     <= event_in;
      product_ff   <= product_in;
      rsp_event_ff <= rsp_event_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_bpm_ff   <= rsp_bpm_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_period = rsp_event_ff;
   assign rsp_step_index   = rsp_step_ff;
   assign rsp_current_bpm  = rsp_bpm_ff;

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      period_ff != '0)
      else $error("step period reached zero");

   a_bpm_range: assert property (@(posedge clock) disable iff (reset)
      bpm_ff <= tscr_pkg::MS_PER_MIN)
      else $error("derived tempo out of range");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

endmodule

[rtl/tscr_ctrl.sv]
// ----------------------------------------------------------------------------
// tscr_ctrl
// Controller: sequences writes, ticks, the multiply and the divider passes.
// ----------------------------------------------------------------------------
module tscr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tscr_pkg::status_type   status,
   output tscr_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      S_IDLE       = 9'b000000001,
      S_MUL        = 9'b000000010,
      S_SCALE_GO   = 9'b000000100,
      S_SCALE_WAIT = 9'b000001000,
      S_BPM_GO     = 9'b000010000,
      S_BPM_WAIT   = 9'b000100000,
      S_TEMPO_WAIT = 9'b001000000,
      S_WRAP_WAIT  = 9'b010000000,
      S_DONE       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      resync_ff, resync_in;

   always_comb begin
      state_in  = state_ff;
      resync_in = resync_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.cfg_write = 1'b1;
               if (status.cfg_tempo_div) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = tscr_pkg::DSEL_TEMPO;
                  state_in      = S_TEMPO_WAIT;
               end else if (status.cfg_ratio_change) begin
                  resync_in = 1'b0;
                  state_in  = S_MUL;
               end
            end else if (req_valid) begin
               cmd.tick = 1'b1;
               if (status.mp_nonzero) begin
                  if (status.resync_due) begin
                     resync_in = 1'b1;
                     state_in  = S_MUL;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (status.step_due && !status.wrap_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = tscr_pkg::DSEL_WRAP;
                  state_in      = S_WRAP_WAIT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SCALE_GO;
         end
         S_SCALE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tscr_pkg::DSEL_SCALE;
            state_in      = S_SCALE_WAIT;
         end
         S_SCALE_WAIT: begin
            cmd.div_sel = tscr_pkg::DSEL_SCALE;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = S_BPM_GO;
            end
         end
         S_BPM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = tscr_pkg::DSEL_BPM;
            state_in      = S_BPM_WAIT;
         end
         S_BPM_WAIT: begin
            cmd.div_sel = tscr_pkg::DSEL_BPM;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (resync_ff) begin
                  cmd.finish_resync = 1'b1;
                  state_in          = S_DONE;
               end else begin
                  cmd.finish_ratio = 1'b1;
                  state_in         = S_IDLE;
               end
            end
         end
         S_TEMPO_WAIT: begin
            cmd.div_sel = tscr_pkg::DSEL_TEMPO;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_WRAP_WAIT: begin
            cmd.div_sel = tscr_pkg::DSEL_WRAP;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         resync_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         resync_ff <= resync_in;
      end
   end

   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && csr_valid && csr_ready))
      else $error("tick and register write taken together");

   a_store_on_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_store |-> status.div_done)
      else $error("divider result stored before done");

   a_plain_tick: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && !status.mp_nonzero && !status.step_due) |=> state_ff == S_DONE)
      else $error("plain tick did not go straight to result");

endmodule

[rtl/tempo_step_clock_with_ratio_sync.sv]
// ----------------------------------------------------------------------------
// tempo_step_clock_with_ratio_sync
// Millisecond step clock that follows a tempo or resyncs to a master clock
// through a numerator/denominator ratio.
//
//   port group   direction   beat contents
//   req_*        in          one 1 ms tick, master_period (0 = none)
//   rsp_*        out         event_period, step_index, current_bpm
//   csr_*        in          register index and write data
//
// work from accept to the result beat: a plain tick or master pulse without
// resync goes straight to the result, a step that wraps through step_wrap
// takes one divider pass and a resync the multiply and two passes; a ratio
// write (multiply, two passes) or a tempo write (one pass) runs before the
// next beat is taken; reset is synchronous; no clearing pass; a waiting
// result does not block the next tick, which is taken as soon as the
// controller is back in idle and no register write is waiting
module tempo_step_clock_with_ratio_sync (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tscr_pkg::PERIOD_W-1:0]       req_master_period,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tscr_pkg::PERIOD_W-1:0]       rsp_event_period,
   output logic [tscr_pkg::STEP_W-1:0]         rsp_step_index,
   output logic [tscr_pkg::PERIOD_W-1:0]       rsp_current_bpm,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tscr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tscr_pkg::CSR_DATA_W-1:0]     csr_data
);

   tscr_pkg::cmd_type    cmd;
   tscr_pkg::status_type status;

   tscr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tscr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_master_period (req_master_period),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_period  (rsp_event_period),
      .rsp_step_index    (rsp_step_index),
      .rsp_current_bpm   (rsp_current_bpm)
   );

endmodule
